// ===== hw/rtl/ictw_pkg.sv =====
// Package: types and constants shared by the idle connection timeout wheel.
package ictw_pkg;

  localparam int unsigned CONNECTIONS_DEF = 64;
  localparam int unsigned COUNT_W         = 8;
  localparam int unsigned CONN_W          = 6;
  localparam logic [COUNT_W-1:0] IDLE_RESET = 8'd10;

  typedef enum logic [1:0] {
    OP_CONNECT    = 2'd0,
    OP_MESSAGE    = 2'd1,
    OP_TICK       = 2'd2,
    OP_DISCONNECT = 2'd3
  } op_t;

  typedef struct packed {
    op_t               opcode;
    logic [CONN_W-1:0] conn_id;
  } in_item_t;

  typedef struct packed {
    logic [CONN_W-1:0] closed_conn;
    logic              last;
  } out_item_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic               evt;    // connect, message or disconnect beat taken
    logic               tick;   // tick beat taken
    logic               shift;  // hand expiry flags one cell toward the head
    op_t                op;
    logic [CONN_W-1:0]  conn_id;
    logic [COUNT_W-1:0] load;   // idle limit, zero mapped to one
  } cell_ctl_t;

endpackage

// ===== hw/rtl/ictw_cell.sv =====
// Cell: countdown and expiry flag of one connection slot.
module ictw_cell #(
  parameter int unsigned SLOT = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ictw_pkg::cell_ctl_t ctl,
  input  logic                flag_in,
  output logic                flag_out
);
  import ictw_pkg::*;

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               flag_r, flag_nxt;
  logic               hit;

  assign hit = ctl.evt && (32'(ctl.conn_id) == SLOT);

  always_comb begin
    count_nxt = count_r;
    flag_nxt  = flag_r;
    if (ctl.tick) begin
      if (count_r != '0) begin
        count_nxt = count_r - 1'b1;
      end
      flag_nxt = (count_r == COUNT_W'(1));
    end else if (ctl.shift) begin
      flag_nxt = flag_in;
    end
    if (hit) begin
      case (ctl.op)
        OP_CONNECT:    count_nxt = ctl.load;
        OP_MESSAGE:    if (count_r != '0) count_nxt = ctl.load;
        OP_DISCONNECT: count_nxt = '0;
        default:       count_nxt = count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      flag_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      flag_r  <= flag_nxt;
    end
  end

  assign flag_out = flag_r;

endmodule

// ===== hw/rtl/idle_connection_timeout_wheel.sv =====
// Top level: idle connection timeout wheel built from a row of slot cells.
//
// Usage:
//   Input beats (in_valid/in_stall, payload in_item) carry connect, message,
//   tick and disconnect events. Connect, message and disconnect update the
//   addressed slot when taken and produce no result; a slot id that is not
//   below CONNECTIONS is dropped. A tick decrements every live countdown in
//   the cycle it is taken and marks each slot that reaches zero.
//   The marks then move one cell per cycle toward the head of the row unless
//   the scan is frozen, and the input stalls until the scan of a tick ends.
//   Each marked slot leaves as one result beat (out_valid/out_stall, payload
//   out_item) in ascending slot order; the final one of a tick has last set.
//   One notice is held back so the last marker is known when it is sent.
//   A stalled result beat holds the marks in the cells once another mark reaches the head.
//   Other events are taken while a finished notice still waits at the output.
//   The idle limit is written over cfg_valid/cfg_ready (always ready); a
//   value of zero acts as one. Reset clears every countdown (no tracked
//   connections), empties the output and sets the idle limit to 10.
module idle_connection_timeout_wheel #(
  parameter int unsigned CONNECTIONS = ictw_pkg::CONNECTIONS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  ictw_pkg::in_item_t         in_item,
  output logic                       out_valid,
  input  logic                       out_stall,
  output ictw_pkg::out_item_t        out_item,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ictw_pkg::COUNT_W-1:0] cfg_data
);
  import ictw_pkg::*;

  localparam int unsigned IDX_W = $clog2(CONNECTIONS + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  logic [COUNT_W-1:0] idle_r;
  logic [IDX_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic               pend_valid_r, pend_valid_nxt;
  logic [CONN_W-1:0]  pend_id_r, pend_id_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r, out_nxt;

  logic               in_take;
  logic               out_free;
  logic               advance;
  logic               scan_end;
  logic [31:0]        idx_wide;
  cell_ctl_t          ctl;
  logic [CONNECTIONS:0] flag_chain;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign scan_end  = (scan_idx_r == IDX_W'(CONNECTIONS));
  assign idx_wide  = 32'(scan_idx_r);

  // Step the row unless a found notice must wait behind a stalled output.
  assign advance = (state_r == ST_SCAN) && !scan_end &&
                   !(flag_chain[0] && pend_valid_r && !out_free);

  always_comb begin
    ctl         = '0;
    ctl.op      = in_item.opcode;
    ctl.conn_id = in_item.conn_id;
    ctl.load    = (idle_r == '0) ? COUNT_W'(1) : idle_r;
    ctl.tick    = in_take && (in_item.opcode == OP_TICK);
    ctl.evt     = in_take && (in_item.opcode != OP_TICK);
    ctl.shift   = advance;
  end

  // Row of cells; expiry flags drain toward cell 0, the head.
  assign flag_chain[CONNECTIONS] = 1'b0;
  for (genvar g = 0; g < CONNECTIONS; g++) begin : g_cell
    ictw_cell #(
      .SLOT(g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .flag_in  (flag_chain[g+1]),
      .flag_out (flag_chain[g])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    scan_idx_nxt   = scan_idx_r;
    pend_valid_nxt = pend_valid_r;
    pend_id_nxt    = pend_id_r;
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    // Drop the output beat once the receiver takes it.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (ctl.tick) begin
          state_nxt      = ST_SCAN;
          scan_idx_nxt   = '0;
          pend_valid_nxt = 1'b0;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          // Flush the held notice as the last one of this tick.
          if (!pend_valid_r) begin
            state_nxt = ST_IDLE;
          end else if (out_free) begin
            out_valid_nxt       = 1'b1;
            out_nxt.closed_conn = pend_id_r;
            out_nxt.last        = 1'b1;
            pend_valid_nxt      = 1'b0;
            state_nxt           = ST_IDLE;
          end
        end else if (advance) begin
          scan_idx_nxt = scan_idx_r + 1'b1;
          if (flag_chain[0]) begin
            if (pend_valid_r) begin
              out_valid_nxt       = 1'b1;
              out_nxt.closed_conn = pend_id_r;
              out_nxt.last        = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_id_nxt    = idx_wide[CONN_W-1:0];
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idle_r       <= IDLE_RESET;
      scan_idx_r   <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      scan_idx_r   <= scan_idx_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        idle_r <= cfg_data;
      end
    end
  end

  // Payload registers hold without reset.
  always_ff @(posedge clk) begin
    pend_id_r <= pend_id_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
